// ----- src/pfl_pkg.sv -----
// Shared types and constants of the page free list allocator.
package pfl_pkg;

    // Width of a page number on the channels
    localparam int PAGE_W = 12;

    // Request kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_BAD_PAGE = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_GROW,
        ST_HOLD
    } state_t;

    // One result transaction
    typedef struct packed {
        logic [PAGE_W-1:0] page_out;
        status_t           status;
    } res_t;

endpackage

// ----- src/pfl_req_if.sv -----
// Request channel interface: allocate or free transactions.
interface pfl_req_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [pfl_pkg::PAGE_W-1:0] page;

    modport source (output valid, output mode, output page, input ready);
    modport sink (input valid, input mode, input page, output ready);
endinterface

// ----- src/pfl_res_if.sv -----
// Result channel interface: allocated page and status.
interface pfl_res_if;
    logic                       valid;
    logic                       ready;
    logic [pfl_pkg::PAGE_W-1:0] page_out;
    pfl_pkg::status_t           status;

    modport source (output valid, output page_out, output status, input ready);
    modport sink (input valid, input page_out, input status, output ready);
endinterface

// ----- src/pfl_link_mem.sv -----
// Link store: one write port, one read port, registered read data.
module pfl_link_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [AW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [AW-1:0] rdata
);

    logic [AW-1:0] links_mem [DEPTH];
    logic [AW-1:0] rdata_reg;

    // Write the link of one page
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            links_mem[waddr] <= wdata;
        end
    end

    // Read one link, available the next cycle
    always_ff @(posedge clk)
    begin
        rdata_reg <= links_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/pfl_ctrl.sv -----
// Free list controller: head, page count, growth sequencer and result hand-off.
module pfl_ctrl #(
    parameter int MAX_PAGES  = 4096,
    parameter int GROW_BATCH = 100,
    parameter int AW         = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // request side
    input  logic                       req_valid,
    input  logic                       req_mode,
    input  logic [pfl_pkg::PAGE_W-1:0] req_page,
    output logic                       req_ready,
    // result side
    input  logic                       slot_free,
    output logic                       emit_valid,
    output pfl_pkg::res_t              emit_res,
    // link store
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic [AW-1:0]              mem_wdata,
    output logic [AW-1:0]              mem_raddr,
    input  logic [AW-1:0]              mem_rdata
);

    localparam int PW = pfl_pkg::PAGE_W;
    localparam int CW = $clog2(MAX_PAGES + 1);
    localparam int BW = $clog2(GROW_BATCH + 1);
    localparam int XW = CW + PW;
    localparam int SW = ((CW > 11) ? CW : 11) + 1;

    pfl_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   wp_reg, wp_next;
    logic [BW-1:0]   bc_reg, bc_next;
    pfl_pkg::res_t   hold_reg, hold_next;

    logic            pend;
    pfl_pkg::res_t   pend_res;
    logic            accept;
    logic            bad_page;
    logic            no_room;
    logic            last_link;
    logic [AW-1:0]   base;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == pfl_pkg::ST_IDLE);
    assign base      = count_reg[AW-1:0];
    assign bad_page  = (req_page == '0) || (XW'(req_page) >= XW'(count_reg));
    assign no_room   = (SW'(count_reg) + SW'(GROW_BATCH)) > SW'(MAX_PAGES);
    assign last_link = (bc_reg == BW'(GROW_BATCH - 1));

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfl_pkg::ST_IDLE;
            head_reg  <= '0;
            count_reg <= CW'(1);
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Growth pointers and held result
    always_ff @(posedge clk)
    begin
        wp_reg   <= wp_next;
        bc_reg   <= bc_next;
        hold_reg <= hold_next;
    end

    // Next state, store accesses and result
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        wp_next    = wp_reg;
        bc_next    = bc_reg;
        hold_next  = hold_reg;
        mem_we     = 1'b0;
        mem_waddr  = wp_reg;
        mem_wdata  = '0;
        mem_raddr  = head_reg;
        pend       = 1'b0;
        pend_res   = '{page_out: '0, status: pfl_pkg::STATUS_OK};
        emit_valid = 1'b0;
        emit_res   = hold_reg;

        unique case (state_reg)
            pfl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_mode == pfl_pkg::MODE_FREE)
                    begin
                        // push onto the head, or reject a bad page
                        pend = 1'b1;
                        if (bad_page)
                        begin
                            pend_res.status = pfl_pkg::STATUS_BAD_PAGE;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(req_page);
                            mem_wdata = head_reg;
                            head_next = AW'(req_page);
                        end
                    end
                    else if (head_reg != '0)
                    begin
                        // fetch the head's link
                        state_next = pfl_pkg::ST_POP;
                    end
                    else if (no_room)
                    begin
                        pend            = 1'b1;
                        pend_res.status = pfl_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        wp_next    = base;
                        bc_next    = '0;
                        state_next = pfl_pkg::ST_GROW;
                    end
                end
            end

            pfl_pkg::ST_POP:
            begin
                // advance the head to the fetched link
                head_next         = mem_rdata;
                pend              = 1'b1;
                pend_res.page_out = PW'(head_reg);
            end

            pfl_pkg::ST_GROW:
            begin
                // chain one fresh page per cycle, end the chain with zero
                mem_we    = 1'b1;
                mem_waddr = wp_reg;
                mem_wdata = last_link ? '0 : wp_reg + AW'(1);
                wp_next   = wp_reg + AW'(1);
                bc_next   = bc_reg + BW'(1);
                if (last_link)
                begin
                    count_next        = count_reg + CW'(GROW_BATCH);
                    head_next         = (GROW_BATCH == 1) ? '0 : base + AW'(1);
                    pend              = 1'b1;
                    pend_res.page_out = PW'(base);
                end
            end

            pfl_pkg::ST_HOLD:
            begin
                if (slot_free)
                begin
                    emit_valid = 1'b1;
                    state_next = pfl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pfl_pkg::ST_IDLE;
            end
        endcase

        // Hand the result over, or hold it until the output slot frees
        if (pend)
        begin
            if (slot_free)
            begin
                emit_valid = 1'b1;
                emit_res   = pend_res;
                state_next = pfl_pkg::ST_IDLE;
            end
            else
            begin
                hold_next  = pend_res;
                state_next = pfl_pkg::ST_HOLD;
            end
        end
    end

    // A pop only starts from a non-empty list
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pfl_pkg::ST_POP |-> head_reg != '0)
        else $error("pop entered with empty list");

    // The page count stays within the store
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (SW'(count_reg) <= SW'(MAX_PAGES)))
        else $error("page count out of range");

    // Growth only runs when the batch fits
    a_grow_fits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pfl_pkg::ST_GROW |-> !no_room && (head_reg == '0))
        else $error("growth without room or with non-empty list");

    // An allocate on a non-empty list reads its link next cycle
    a_alloc_pop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_mode == pfl_pkg::MODE_ALLOC) && (head_reg != '0)
        |=> state_reg == pfl_pkg::ST_POP)
        else $error("allocate did not proceed to pop");

endmodule

// ----- src/page_free_list_allocator_unit.sv -----
// Top level of the page free list allocator: controller, link store, output register.
//
//  channel | role   | payload          | transaction when
//  --------+--------+------------------+-------------------------
//  req     | sink   | mode, page       | req.valid && req.ready
//  res     | source | page_out, status | res.valid && res.ready
//
// One request is worked at a time; req.ready is high while the controller idles.
// Free: handled in the idle state. Allocate from a non-empty list: a pop state
// takes the head's link from the registered read of the link store. Allocate that grows
// the list: one link written per cycle through the store's single write port.
// A finished result sits in the output register; a further request is taken while
// it waits, and its result is held in the controller until the register frees.
// Reset empties the list and sets the page count to one; the link store is not cleared.
module page_free_list_allocator_unit #(
    parameter int MAX_PAGES  = 4096,
    parameter int GROW_BATCH = 100
) (
    input  logic      clk,
    input  logic      rst_n,
    pfl_req_if.sink   req,
    pfl_res_if.source res
);

    localparam int AW = $clog2(MAX_PAGES);

    logic          slot_free;
    logic          emit_valid;
    pfl_pkg::res_t emit_res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] mem_rdata;

    logic          out_valid_reg, out_valid_next;
    pfl_pkg::res_t out_data_reg, out_data_next;

    pfl_ctrl #(
        .MAX_PAGES  (MAX_PAGES),
        .GROW_BATCH (GROW_BATCH),
        .AW         (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_mode   (req.mode),
        .req_page   (req.page),
        .req_ready  (req.ready),
        .slot_free  (slot_free),
        .emit_valid (emit_valid),
        .emit_res   (emit_res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    pfl_link_mem #(
        .DEPTH (MAX_PAGES),
        .AW    (AW)
    ) u_link_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register frees when empty or being taken this cycle
    assign slot_free = !out_valid_reg || res.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_res;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign res.valid    = out_valid_reg;
    assign res.page_out = out_data_reg.page_out;
    assign res.status   = out_data_reg.status;

    // A result is only handed over into a free output register
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid |-> slot_free)
        else $error("result handed over into a full output register");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result lost");

    // An accepted free on a free output register answers next cycle
    a_free_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.mode == pfl_pkg::MODE_FREE) && slot_free
        |=> out_valid_reg)
        else $error("free result not delivered");

endmodule
